FILE: design/ppu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppu_pkg
// shared types and constants of the particle pool update block
// ----------------------------------------------------------------------------
package ppu_pkg;

	localparam int unsigned MAX_OUT = 64;
	localparam int unsigned LONG_FRAME_BASE = 20;
	localparam int unsigned LONG_FRAME_SPAN = 18;
	localparam int unsigned VIEW_MARGIN = 32 * 16;

	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic [2:0] REG_VIEW_COL = 3'd0;
	localparam logic [2:0] REG_VIEW_ROW = 3'd1;
	localparam logic [2:0] REG_VIEW_COLS = 3'd2;
	localparam logic [2:0] REG_VIEW_ROWS = 3'd3;
	localparam logic [2:0] REG_FRAME_COUNT = 3'd4;

	typedef struct packed {
		logic action;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [11:0] vel_x;
		logic signed [11:0] vel_y;
		logic long_life;
	} item_t;

	typedef struct packed {
		logic [9:0] slot;
		logic signed [19:0] screen_x;
		logic signed [19:0] screen_y;
		logic [7:0] frame;
		logic last;
	} result_t;

	// one pool entry as stored in memory
	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [11:0] vx;
		logic signed [11:0] vy;
		logic [7:0] life;
		logic long_f;
	} entry_t;

endpackage
`default_nettype wire

FILE: design/ppu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppu_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module ppu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: design/particle_pool_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_pool_update
// fixed pool of moving particles: add, move, cull and emit visible ones
// ----------------------------------------------------------------------------
// add: fills slots in order; once full, takes the first dead slot from the cursor on
// tick: walks the filled slots, one pool entry read per cycle; busy stays low if empty
// sprites lag the walk by one visible slot, the final one comes in the flush cycle
// results come with a one-cycle strobe; the receiver cannot stall
// reset clears counters and control, config takes defaults; ram stays undefined
module particle_pool_update #(
	parameter int unsigned POOL_SIZE = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire ppu_pkg::item_t item,
	output logic result_valid,
	output ppu_pkg::result_t result,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [11:0] cfg_data
);
	import ppu_pkg::*;

	localparam int unsigned AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int unsigned CW = $clog2(POOL_SIZE + 1);
	localparam logic [CW-1:0] POOL_FULL = CW'(POOL_SIZE);
	localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SIZE - 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_ADD_WR, ST_SEARCH, ST_TICK, ST_DONE, ST_FLUSH
	} state_t;

	state_t state_q;
	item_t item_q;

	// configuration registers
	logic [11:0] view_col_q, view_row_q;
	logic [7:0] view_cols_q, view_rows_q, frame_count_q;

	logic [CW-1:0] fill_q;
	logic [AW-1:0] cursor_q;
	logic [AW-1:0] rd_addr_q;   // address currently being read
	logic [4:0] rd_mod_q;       // rd_addr_q mod the long-life frame span
	logic [AW-1:0] slot_s1;     // slot whose data appears on ram output
	logic [4:0] mod_s1;         // slot_s1 mod the long-life frame span
	logic rd_valid_s1;          // ram output is an entry to process
	logic [6:0] count_q;        // results emitted this tick

	// newest sprite held back so the final one of a tick can be marked
	result_t hold_q;
	logic hold_valid_q;

	// ram
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t ram_wdata, ram_rdata;

	ppu_ram #(.WIDTH($bits(entry_t)), .DEPTH(POOL_SIZE)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// window bounds, signed 26 bits is enough for 512*(4095+255)+512
	logic signed [25:0] min_x, min_y, max_x, max_y;
	assign min_x = $signed({1'b0, view_col_q, 9'd0}) - 26'sd512;
	assign min_y = $signed({1'b0, view_row_q, 9'd0}) - 26'sd512;
	assign max_x = $signed({1'b0, 13'(view_col_q) + 13'(view_cols_q), 9'd0}) + 26'sd512;
	assign max_y = $signed({1'b0, 13'(view_row_q) + 13'(view_rows_q), 9'd0}) + 26'sd512;

	// tick processing of the entry on the ram output
	entry_t upd;
	logic alive, vis, emit;
	logic [7:0] nl, frame_n;

	always_comb begin
		upd = ram_rdata;
		alive = ram_rdata.life != 8'd0;
		upd.x = ram_rdata.x + 24'(ram_rdata.vx);
		upd.y = ram_rdata.y + 24'(ram_rdata.vy);
		nl = ram_rdata.life - 8'd1;
		vis = ($signed(26'(upd.x)) >= min_x) && ($signed(26'(upd.x)) <= max_x)
			&& ($signed(26'(upd.y)) >= min_y) && ($signed(26'(upd.y)) <= max_y);
		upd.life = vis ? nl : 8'd0;
		// normal frame
		if (nl < frame_count_q) begin
			frame_n = frame_count_q - nl;
		end else begin
			frame_n = nl - frame_count_q;
		end
		if (frame_n >= frame_count_q) begin
			frame_n = frame_count_q - 8'd1;
		end
		if (ram_rdata.long_f) begin
			frame_n = 8'(LONG_FRAME_BASE) + 8'(mod_s1);
		end
		emit = alive && vis && (nl != 8'd0) && (frame_n < frame_count_q)
			&& (count_q < 7'(MAX_OUT));
	end

	logic [7:0] new_life;
	assign new_life = item_q.long_life ? {frame_count_q[6:0], 1'b0} : frame_count_q;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = slot_s1;
		ram_wdata = upd;
		ram_raddr = rd_addr_q;
		unique case (state_q)
			ST_ADD_WR: begin
				ram_we = 1'b1;
				ram_waddr = rd_addr_q;
				ram_wdata = '{x: item_q.pos_x, y: item_q.pos_y, vx: item_q.vel_x,
					vy: item_q.vel_y, life: new_life, long_f: item_q.long_life};
			end
			ST_TICK, ST_DONE: begin
				ram_we = rd_valid_s1 && alive;
			end
			default: ;
		endcase
	end

	assign busy = state_q != ST_IDLE;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_col_q <= '0;
			view_row_q <= '0;
			view_cols_q <= 8'd64;
			view_rows_q <= 8'd64;
			frame_count_q <= 8'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VIEW_COL: view_col_q <= cfg_data;
				REG_VIEW_ROW: view_row_q <= cfg_data;
				REG_VIEW_COLS: view_cols_q <= cfg_data[7:0];
				REG_VIEW_ROWS: view_rows_q <= cfg_data[7:0];
				REG_FRAME_COUNT: frame_count_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			cursor_q <= '0;
			rd_addr_q <= '0;
			rd_mod_q <= '0;
			slot_s1 <= '0;
			mod_s1 <= '0;
			rd_valid_s1 <= 1'b0;
			count_q <= '0;
			hold_q <= '0;
			hold_valid_q <= 1'b0;
			result_valid <= 1'b0;
			result <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					result_valid <= 1'b0;
					rd_valid_s1 <= 1'b0;
					if (start) begin
						count_q <= '0;
						if (item.action == ACT_TICK) begin
							rd_addr_q <= '0;
							rd_mod_q <= '0;
							state_q <= (fill_q == '0) ? ST_IDLE : ST_TICK;
						end else if (fill_q < POOL_FULL) begin
							rd_addr_q <= AW'(fill_q);
							fill_q <= fill_q + 1'b1;
							cursor_q <= (fill_q == POOL_FULL - 1'b1) ? '0 : cursor_q + 1'b1;
							state_q <= ST_ADD_WR;
						end else begin
							rd_addr_q <= cursor_q;
							slot_s1 <= cursor_q;
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_ADD_WR: begin
					result_valid <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_SEARCH: begin
					// per slot: address out, then data back for slot_s1
					result_valid <= 1'b0;
					if (rd_valid_s1) begin
						rd_valid_s1 <= 1'b0;
						if (ram_rdata.life == 8'd0) begin
							rd_addr_q <= slot_s1;
							cursor_q <= (slot_s1 == LAST_SLOT) ? '0 : slot_s1 + 1'b1;
							state_q <= ST_ADD_WR;
						end else if (slot_s1 == LAST_SLOT) begin
							cursor_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							slot_s1 <= slot_s1 + 1'b1;
							rd_addr_q <= slot_s1 + 1'b1;
						end
					end else begin
						rd_valid_s1 <= 1'b1;
						rd_addr_q <= slot_s1;
					end
				end
				ST_TICK, ST_DONE: begin
					// issue reads, then process the entry the ram returns for slot_s1
					rd_valid_s1 <= state_q == ST_TICK;
					slot_s1 <= rd_addr_q;
					mod_s1 <= rd_mod_q;
					if (state_q == ST_TICK) begin
						if (CW'(rd_addr_q) == fill_q - 1'b1) begin
							state_q <= ST_DONE;
						end else begin
							rd_addr_q <= rd_addr_q + 1'b1;
							rd_mod_q <= (rd_mod_q == 5'(LONG_FRAME_SPAN - 1)) ? '0
								: rd_mod_q + 1'b1;
						end
					end
					// a new sprite pushes the held one out as not last
					result_valid <= rd_valid_s1 && emit && hold_valid_q;
					if (rd_valid_s1 && emit) begin
						count_q <= count_q + 1'b1;
						hold_valid_q <= 1'b1;
						hold_q <= '{slot: 10'(slot_s1),
							screen_x: 20'(upd.x >>> 4) - 20'({view_col_q, 5'd0}),
							screen_y: 20'(upd.y >>> 5) - 20'({view_row_q, 4'd0}),
							frame: frame_n, last: 1'b0};
						if (hold_valid_q) begin
							result <= hold_q;
						end
					end
					if (state_q == ST_DONE) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					// the held sprite is the final one of this tick
					rd_valid_s1 <= 1'b0;
					hold_valid_q <= 1'b0;
					result_valid <= hold_valid_q;
					if (hold_valid_q) begin
						result <= '{slot: hold_q.slot, screen_x: hold_q.screen_x,
							screen_y: hold_q.screen_y, frame: hold_q.frame, last: 1'b1};
					end
					state_q <= ST_IDLE;
				end
				default: begin
					result_valid <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: tb/sv/particle_pool_update_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_pool_update_checker
// tracks the particle pool from accepted transfers and register writes,
// predicts the sprites of every tick and compares them with the block's output
// ----------------------------------------------------------------------------
module particle_pool_update_checker #(
	parameter int POOL = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire ppu_pkg::item_t item,
	input wire logic result_valid,
	input wire ppu_pkg::result_t result,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [11:0] cfg_data,
	output int fail_count,
	output int pending
);
	import ppu_pkg::*;

	int vcol, vrow, vcols, vrows, nframes;
	logic signed [23:0] px [POOL];
	logic signed [23:0] py [POOL];
	logic signed [11:0] pvx [POOL];
	logic signed [11:0] pvy [POOL];
	logic [7:0] plife [POOL];
	logic plong [POOL];
	int fill, cursor;
	result_t sprites_due [$];

	assign pending = sprites_due.size();

	task automatic place_particle(input item_t it);
		int pick;
		int k;
		bit ok;
		pick = 0;
		ok = 0;
		if (fill < POOL) begin
			pick = fill;
			ok = 1;
			fill++;
			cursor++;
			if (fill == POOL) cursor = 0;
		end else begin
			k = cursor;
			while (k < POOL && plife[k] != 0) k++;
			if (k < POOL) begin
				pick = k;
				ok = 1;
				cursor = k + 1;
			end else begin
				cursor = POOL;
			end
		end
		if (cursor >= POOL) cursor = 0;
		if (ok) begin
			px[pick] = it.pos_x;
			py[pick] = it.pos_y;
			pvx[pick] = it.vel_x;
			pvy[pick] = it.vel_y;
			plong[pick] = it.long_life;
			plife[pick] = it.long_life ? 8'((nframes * 2) & 255) : 8'(nframes);
		end
	endtask

	// move, cull and collect the sprites one tick shows
	task automatic advance_pool();
		int lo_x, lo_y, hi_x, hi_y;
		int xi, yi, p, shown;
		result_t r;
		result_t batch [$];
		lo_x = vcol * 512 - int'(VIEW_MARGIN);
		lo_y = vrow * 512 - int'(VIEW_MARGIN);
		hi_x = (vcol + vcols) * 512 + int'(VIEW_MARGIN);
		hi_y = (vrow + vrows) * 512 + int'(VIEW_MARGIN);
		shown = 0;
		for (int i = 0; i < fill; i++) begin
			if (plife[i] == 0) continue;
			xi = px[i];
			yi = py[i];
			xi = xi + pvx[i];
			yi = yi + pvy[i];
			px[i] = xi[23:0];
			py[i] = yi[23:0];
			xi = px[i];
			yi = py[i];
			plife[i] = plife[i] - 8'd1;
			if (xi < lo_x || xi > hi_x || yi < lo_y || yi > hi_y) begin
				plife[i] = 0;
				continue;
			end
			if (plife[i] == 0) continue;
			p = plife[i];
			if (p < nframes) p = nframes - p;
			else p = p - nframes;
			if (p >= nframes) p = nframes - 1;
			if (plong[i]) p = int'(LONG_FRAME_BASE) + i % int'(LONG_FRAME_SPAN);
			if (p < 0 || p >= nframes || shown >= int'(MAX_OUT)) continue;
			r.slot = 10'(i);
			r.screen_x = 20'((xi >>> 4) - vcol * 32);
			r.screen_y = 20'((yi >>> 5) - vrow * 16);
			r.frame = 8'(p);
			r.last = 1'b0;
			batch.push_back(r);
			shown++;
		end
		if (shown > 0) batch[shown - 1].last = 1'b1;
		foreach (batch[j]) sprites_due.push_back(batch[j]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			vcol = 0;
			vrow = 0;
			vcols = 64;
			vrows = 64;
			nframes = 16;
			fill = 0;
			cursor = 0;
			fail_count = 0;
			sprites_due.delete();
		end else begin
			if (result_valid) begin
				if (sprites_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t unexpected sprite slot=%0d x=%0d y=%0d frame=%0d last=%0d",
							$realtime, result.slot, result.screen_x, result.screen_y,
							result.frame, result.last);
				end else begin
					want = sprites_due.pop_front();
					if (result.slot !== want.slot || result.screen_x !== want.screen_x ||
							result.screen_y !== want.screen_y || result.frame !== want.frame ||
							result.last !== want.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t sprite mismatch exp slot=%0d x=%0d y=%0d frame=%0d last=%0d got slot=%0d x=%0d y=%0d frame=%0d last=%0d",
								$realtime, want.slot, want.screen_x, want.screen_y, want.frame,
								want.last, result.slot, result.screen_x, result.screen_y,
								result.frame, result.last);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_VIEW_COL: vcol = cfg_data;
					REG_VIEW_ROW: vrow = cfg_data;
					REG_VIEW_COLS: vcols = cfg_data[7:0];
					REG_VIEW_ROWS: vrows = cfg_data[7:0];
					REG_FRAME_COUNT: nframes = cfg_data[7:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (item.action == ACT_TICK) advance_pool();
				else place_particle(item);
			end
		end
	end

endmodule

FILE: tb/sv/particle_pool_update_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_pool_update_test
// drives adds and ticks through several view and frame settings; a checker
// beside the block predicts every sprite and counts mismatches
// ----------------------------------------------------------------------------
module particle_pool_update_test;
	import ppu_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE = 100;
	localparam int ITEM_W = $bits(item_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	item_t item = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [11:0] cfg_data = '0;
	logic busy;
	logic result_valid;
	result_t result;
	int fail_count;
	int pending;

	// view as last written, for aiming particles into the window
	int cur_col = 0;
	int cur_cols = 64;
	int cur_row = 0;
	int cur_rows = 64;
	int sent = 0;
	int quiet = 0;

	particle_pool_update #(.POOL_SIZE(64)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	particle_pool_update_checker #(.POOL(64)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: any transfer, sprite or register write counts as progress
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || cfg_we) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic item_t mk(logic act, int x, int y, int vx, int vy, logic ll);
		item_t it;
		it.action = act;
		it.pos_x = 24'(x);
		it.pos_y = 24'(y);
		it.vel_x = 12'(vx);
		it.vel_y = 12'(vy);
		it.long_life = ll;
		return it;
	endfunction

	// mostly adds aimed at the window with modest speed, some ticks,
	// and a share of fully random noise
	function automatic item_t rand_item();
		item_t it;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 15) begin
			it = item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
			return it;
		end
		it.action = (roll < 45) ? ACT_TICK : ACT_ADD;
		it.pos_x = 24'(cur_col * 512 - 600 + $urandom_range(0, cur_cols * 512 + 1200));
		it.pos_y = 24'(cur_row * 512 - 600 + $urandom_range(0, cur_rows * 512 + 1200));
		if ($urandom_range(0, 9) == 0) begin
			it.vel_x = 12'($urandom);
			it.vel_y = 12'($urandom);
		end else begin
			it.vel_x = 12'($urandom_range(0, 200) - 100);
			it.vel_y = 12'($urandom_range(0, 200) - 100);
		end
		it.long_life = 1'($urandom);
		return it;
	endfunction

	// hold start until the transfer; start stays high when no gap follows
	task automatic send(input item_t it, input bit may_idle);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		if (may_idle && $urandom_range(0, 99) < 31) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// wait for the last item to finish and its sprites to drain
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (busy || pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_view(input int col, input int row, input int cols, input int rows,
			input int frames);
		logic [2:0] idx [5];
		int val [5];
		idx = '{REG_VIEW_COL, REG_VIEW_ROW, REG_VIEW_COLS, REG_VIEW_ROWS, REG_FRAME_COUNT};
		val = '{col, row, cols, rows, frames};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= 12'(val[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_col = col;
		cur_row = row;
		cur_cols = cols;
		cur_rows = rows;
	endtask

	initial begin
		int col_set [6];
		int row_set [6];
		int cols_set [6];
		int rows_set [6];
		int fc_set [6];
		col_set = '{10, 4095, 0, 100, 7, 2000};
		row_set = '{20, 4095, 0, 3, 4095, 0};
		cols_set = '{64, 255, 0, 32, 255, 8};
		rows_set = '{48, 255, 0, 200, 1, 8};
		fc_set = '{40, 255, 0, 200, 1, 64};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset view: empty pool, window bounds, wrap,
		// long life, culling, then ticks until every short life runs out
		send(mk(ACT_TICK, 0, 0, 0, 0, 1'b0), 1'b1);
		send(mk(ACT_ADD, -512, -512, 0, 0, 1'b0), 1'b1);
		send(mk(ACT_ADD, 33280, 33280, 0, 0, 1'b0), 1'b0);
		send(mk(ACT_ADD, 8388607, 8388607, 2047, 2047, 1'b0), 1'b1);
		send(mk(ACT_ADD, -8388608, -8388608, -2048, -2048, 1'b1), 1'b0);
		send(mk(ACT_ADD, 1000, 2000, 16, -32, 1'b1), 1'b1);
		send(mk(ACT_ADD, -513, 100, 0, 0, 1'b0), 1'b1);
		send(mk(ACT_ADD, 33200, 500, 100, 0, 1'b0), 1'b0);
		send(mk(ACT_ADD, 4000, -400, -3, -7, 1'b0), 1'b1);
		for (int i = 0; i < 16; i++)
			send(mk(ACT_TICK, 0, 0, 0, 0, 1'b0), i % 3 == 0);
		settle();

		// random phases across view and frame settings, extremes included;
		// the middle phases run without gaps
		for (int ph = 0; ph < 6; ph++) begin
			set_view(col_set[ph], row_set[ph], cols_set[ph], rows_set[ph], fc_set[ph]);
			for (int n = 0; n < 42; n++)
				send(rand_item(), !(ph == 2 || ph == 3));
			settle();
		end
		// an unused register index must change nothing
		cfg_we <= 1'b1;
		cfg_index <= 3'd7;
		cfg_data <= 12'hfff;
		@(posedge clk);
		cfg_we <= 1'b0;
		for (int n = 0; n < 10; n++)
			send(rand_item(), 1'b1);
		settle();

		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
